>>> sv/native_pcm_to_pcm24_converter_unit_defines.svh
// Assertion helpers for the converter top level.
`ifndef NATIVE_PCM_TO_PCM24_CONVERTER_UNIT_DEFINES_SVH
`define NATIVE_PCM_TO_PCM24_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define PCM24_ASSERT_IMP(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define PCM24_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> sv/pcm24_pkg.sv
package pcm24_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int MAX_BLOCK_DEFAULT   = 65536;

   localparam int MAG_W    = 26;
   localparam int SQ_W     = 48;
   localparam int ENERGY_W = 63;
   localparam int COUNT_W  = 17;
   localparam int INDEX_W  = 16;
   localparam int CSR_W    = 6;

   typedef enum logic [2:0] {
      CSR_CONTAINER_BYTES = 3'd0,
      CSR_BIG_ENDIAN      = 3'd1,
      CSR_MSB_ALIGNED     = 3'd2,
      CSR_FLOAT_ENCODING  = 3'd3,
      CSR_VALID_BITS      = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_FORMAT    = 2'd1,
      ERR_NONFINITE = 2'd2
   } block_error_type;

   typedef struct packed {
      logic [2:0] container_bytes;
      logic       big_endian;
      logic       msb_aligned;
      logic       float_encoding;
      logic [5:0] valid_bits;
   } cfg_type;

   typedef struct packed {
      logic [31:0] container_word;
      logic        is_last;
   } req_payload_type;

   typedef struct packed {
      logic signed [23:0]    pcm_sample;
      logic                  sample_saturated;
      logic                  sample_nonfinite;
      logic                  block_end;
      logic [1:0]            block_error;
      logic [INDEX_W-1:0]    error_index;
      logic [COUNT_W-1:0]    saturated_total;
      logic [ENERGY_W-1:0]   energy_total;
   } rsp_payload_type;

   // One classified sample waiting for the back end.
   typedef struct packed {
      logic             ok;
      logic             nonfinite;
      logic             neg;
      logic [MAG_W-1:0] mag;
      logic             is_last;
   } decoded_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> sv/pcm24_front.sv
module pcm24_front (
   input  pcm24_pkg::cfg_type         cfg,
   input  pcm24_pkg::req_payload_type req,
   output pcm24_pkg::decoded_type     dec
);
   import pcm24_pkg::*;

   logic              fmt_ok;
   logic [31:0]       word;
   logic [5:0]        bits_in_container;

   logic [7:0]        f_exp;
   logic [7:0]        f_exp_eff;
   logic [23:0]       f_man;
   logic [7:0]        f_up;
   logic [7:0]        f_down;
   logic [24:0]       f_round;
   logic [MAG_W-1:0]  f_mag;
   logic              f_nonfinite;

   logic [5:0]        i_align;
   logic [31:0]       i_shifted;
   logic [32:0]       i_modulus;
   logic [32:0]       i_masked;
   logic              i_sign;
   logic [32:0]       i_abs;
   logic [32:0]       i_up;
   logic [5:0]        i_k;
   logic [33:0]       i_round;
   logic [MAG_W-1:0]  i_mag;

   assign bits_in_container = {cfg.container_bytes, 3'b000};

   always_comb begin
      if (cfg.container_bytes < 3'd2 || cfg.container_bytes > 3'd4) begin
         fmt_ok = 1'b0;
      end else if (cfg.float_encoding) begin
         fmt_ok = (cfg.container_bytes == 3'd4) && (cfg.valid_bits == 6'd32);
      end else begin
         fmt_ok = (cfg.valid_bits >= 6'd16) && (cfg.valid_bits <= 6'd32) &&
                  (cfg.valid_bits <= bits_in_container);
      end
   end

   // Gather container bytes into a word, first significant byte at bit 0.
   always_comb begin
      unique case (cfg.container_bytes)
         3'd2: word = cfg.big_endian ?
                      {16'h0, req.container_word[7:0], req.container_word[15:8]} :
                      {16'h0, req.container_word[15:0]};
         3'd3: word = cfg.big_endian ?
                      {8'h0, req.container_word[7:0], req.container_word[15:8],
                       req.container_word[23:16]} :
                      {8'h0, req.container_word[23:0]};
         3'd4: word = cfg.big_endian ?
                      {req.container_word[7:0], req.container_word[15:8],
                       req.container_word[23:16], req.container_word[31:24]} :
                      req.container_word;
         default: word = '0;
      endcase
   end

   // Float: scale by 2^23, round half away from zero on the magnitude.
   always_comb begin
      f_exp       = word[30:23];
      f_nonfinite = (f_exp == 8'hFF);
      f_exp_eff   = (f_exp == 8'h00) ? 8'd1 : f_exp;
      f_man       = {(f_exp != 8'h00), word[22:0]};
      f_up        = f_exp_eff - 8'd127;
      f_down      = 8'd127 - f_exp_eff;
      f_round     = '0;
      if (f_exp_eff >= 8'd127) begin
         if (f_up >= 8'd2) begin
            f_mag = MAG_W'(1) << 25;
         end else if (f_up == 8'd1) begin
            f_mag = {1'b0, f_man, 1'b0};
         end else begin
            f_mag = {2'b00, f_man};
         end
      end else if (f_down >= 8'd26) begin
         f_mag = '0;
      end else begin
         f_round = {1'b0, f_man} + (25'd1 << (f_down - 8'd1));
         f_mag   = MAG_W'(f_round >> f_down);
      end
   end

   // Integer: align, take the sign, then scale to 24 bits.
   always_comb begin
      i_align   = cfg.msb_aligned ? (bits_in_container - cfg.valid_bits) : 6'd0;
      i_shifted = word >> i_align;
      i_modulus = 33'd1 << cfg.valid_bits;
      i_masked  = {1'b0, i_shifted} & (i_modulus - 33'd1);
      i_sign    = |(i_masked & (33'd1 << (cfg.valid_bits - 6'd1)));
      i_abs     = i_sign ? (i_modulus - i_masked) : i_masked;
      i_k       = cfg.valid_bits - 6'd24;
      i_up      = '0;
      i_round   = '0;
      if (cfg.valid_bits <= 6'd24) begin
         i_up  = i_abs << (6'd24 - cfg.valid_bits);
         i_mag = i_up[MAG_W-1:0];
      end else begin
         i_round = {1'b0, i_abs} + (34'd1 << (i_k - 6'd1));
         i_mag   = MAG_W'(i_round >> i_k);
      end
   end

   always_comb begin
      dec.ok        = fmt_ok;
      dec.nonfinite = fmt_ok && cfg.float_encoding && f_nonfinite;
      dec.neg       = fmt_ok && !dec.nonfinite &&
                      (cfg.float_encoding ? word[31] : i_sign);
      dec.mag       = (fmt_ok && !dec.nonfinite) ?
                      (cfg.float_encoding ? f_mag : i_mag) : '0;
      dec.is_last   = req.is_last;
   end

endmodule

>>> sv/pcm24_queue.sv
module pcm24_queue #(
   parameter int DEPTH = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  pcm24_pkg::decoded_type         push_data,
   input  logic                           pop,
   output pcm24_pkg::decoded_type         pop_data,
   output pcm24_pkg::queue_status_type    status
);
   import pcm24_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   decoded_type       entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

>>> sv/pcm24_back.sv
module pcm24_back #(
   parameter int MAX_BLOCK = 65536
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  pcm24_pkg::decoded_type       q_data,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output pcm24_pkg::rsp_payload_type   rsp_payload
);
   import pcm24_pkg::*;

   localparam int IDX_CAP = (MAX_BLOCK - 1 > 65535) ? 65535 : MAX_BLOCK - 1;

   // Stage 1: clip and square.
   logic              s1_valid_ff, s1_valid_in;
   logic [23:0]       s1_pcm_ff;
   logic              s1_sat_ff;
   logic              s1_nf_ff;
   logic              s1_ok_ff;
   logic              s1_last_ff;
   logic [SQ_W-1:0]   s1_sq_ff;

   logic [23:0]       lim;
   logic              sat;
   logic [23:0]       mag_clip;

   // Stage 2: block totals and the result register.
   logic [INDEX_W-1:0]  sample_index_ff, sample_index_in;
   logic [COUNT_W-1:0]  sat_count_ff, sat_count_in;
   logic [ENERGY_W-1:0] energy_ff, energy_in;
   logic                seen_ff, seen_in;
   logic [INDEX_W-1:0]  first_bad_ff, first_bad_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_payload_ff, rsp_payload_in;

   logic                out_free;
   logic                s1_adv;
   logic                seen_new;
   logic [INDEX_W-1:0]  first_new;
   logic [COUNT_W-1:0]  count_new;
   logic [ENERGY_W:0]   energy_sum;
   logic [ENERGY_W-1:0] energy_new;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign s1_adv      = s1_valid_ff && out_free;
   assign q_pop       = q_valid && (!s1_valid_ff || out_free);
   assign s1_valid_in = q_pop || (s1_valid_ff && !out_free);

   always_comb begin
      lim      = q_data.neg ? 24'h800000 : 24'h7FFFFF;
      sat      = (q_data.mag > {2'b00, lim});
      mag_clip = sat ? lim : q_data.mag[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_pcm_ff  <= q_data.neg ? (24'd0 - mag_clip) : mag_clip;
         s1_sat_ff  <= sat;
         s1_nf_ff   <= q_data.nonfinite;
         s1_ok_ff   <= q_data.ok;
         s1_last_ff <= q_data.is_last;
         s1_sq_ff   <= mag_clip * mag_clip;
      end
   end

   always_comb begin
      seen_new   = seen_ff || s1_nf_ff;
      first_new  = (s1_nf_ff && !seen_ff) ? sample_index_ff : first_bad_ff;
      count_new  = (s1_sat_ff && (sat_count_ff != '1)) ? sat_count_ff + COUNT_W'(1)
                                                       : sat_count_ff;
      energy_sum = {1'b0, energy_ff} + {{(ENERGY_W + 1 - SQ_W){1'b0}}, s1_sq_ff};
      energy_new = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];

      rsp_payload_in.pcm_sample       = s1_pcm_ff;
      rsp_payload_in.sample_saturated = s1_sat_ff;
      rsp_payload_in.sample_nonfinite = s1_nf_ff;
      rsp_payload_in.block_end        = s1_last_ff;
      rsp_payload_in.block_error      = !s1_ok_ff ? ERR_FORMAT :
                                        (seen_new ? ERR_NONFINITE : ERR_NONE);
      rsp_payload_in.error_index      = seen_new ? first_new : '0;
      rsp_payload_in.saturated_total  = count_new;
      rsp_payload_in.energy_total     = energy_new;

      sample_index_in = sample_index_ff;
      sat_count_in    = sat_count_ff;
      energy_in       = energy_ff;
      seen_in         = seen_ff;
      first_bad_in    = first_bad_ff;
      if (s1_adv) begin
         if (s1_last_ff) begin
            sample_index_in = '0;
            sat_count_in    = '0;
            energy_in       = '0;
            seen_in         = 1'b0;
            first_bad_in    = '0;
         end else begin
            sat_count_in = count_new;
            energy_in    = energy_new;
            seen_in      = seen_new;
            first_bad_in = first_new;
            if (sample_index_ff < INDEX_W'(IDX_CAP)) begin
               sample_index_in = sample_index_ff + INDEX_W'(1);
            end
         end
      end

      rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff <= '0;
         sat_count_ff    <= '0;
         energy_ff       <= '0;
         seen_ff         <= 1'b0;
         first_bad_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         sample_index_ff <= sample_index_in;
         sat_count_ff    <= sat_count_in;
         energy_ff       <= energy_in;
         seen_ff         <= seen_in;
         first_bad_ff    <= first_bad_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> sv/native_pcm_to_pcm24_converter_unit.sv
// Native PCM container to signed 24-bit PCM converter.
// req_*: one raw container word per request (valid/ready), is_last closes a block.
// rsp_*: one result per request (valid/ready): the 24-bit sample, its clip and
//   non-finite flags, and the running block totals (clip count, energy, first
//   non-finite index, error code). Totals cover the whole block on block_end.
// csr_*: plain write port; csr_we writes csr_wdata to register csr_index at the
//   clock edge, no wait. Change format only while the block is idle.
// Path: an accepted request is decoded by the front into the queue, then
//   registered in the clip/square stage, then accumulated into the result register.
// Throughput: one request per clock while the result register is free or taken;
//   a result held by rsp_ready low stalls the clip stage and then the queue.
// Stall: the result register holds until taken; the queue keeps filling, the clip
//   stage fills only if empty, and req_ready drops only when the queue is full.
// Reset (synchronous, active high): format returns to 2-byte little-endian
//   16-bit integer, block totals clear, queue and pipeline empty.
`include "native_pcm_to_pcm24_converter_unit_defines.svh"

module native_pcm_to_pcm24_converter_unit #(
   parameter int MAX_BLOCK   = pcm24_pkg::MAX_BLOCK_DEFAULT,
   parameter int QUEUE_DEPTH = pcm24_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  pcm24_pkg::req_payload_type    req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output pcm24_pkg::rsp_payload_type    rsp_payload,
   input  logic                          csr_we,
   input  logic [2:0]                    csr_index,
   input  logic [pcm24_pkg::CSR_W-1:0]   csr_wdata
);
   import pcm24_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   decoded_type       front_dec;
   decoded_type       q_data;
   queue_status_type  q_status;
   logic              q_push;
   logic              q_pop;

   // Format registers; writes beyond the register list drop.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CONTAINER_BYTES: cfg_in.container_bytes = csr_wdata[2:0];
            CSR_BIG_ENDIAN:      cfg_in.big_endian      = csr_wdata[0];
            CSR_MSB_ALIGNED:     cfg_in.msb_aligned     = csr_wdata[0];
            CSR_FLOAT_ENCODING:  cfg_in.float_encoding  = csr_wdata[0];
            CSR_VALID_BITS:      cfg_in.valid_bits      = csr_wdata[5:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.container_bytes <= 3'd2;
         cfg_ff.big_endian      <= 1'b0;
         cfg_ff.msb_aligned     <= 1'b0;
         cfg_ff.float_encoding  <= 1'b0;
         cfg_ff.valid_bits      <= 6'd16;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: assemble and classify each request as it is accepted.
   pcm24_front u_front (
      .cfg (cfg_ff),
      .req (req_payload),
      .dec (front_dec)
   );

   assign req_ready = !q_status.full;
   assign q_push    = req_valid && req_ready;

   // Queue: decouple acceptance from the back end.
   pcm24_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_dec),
      .pop       (q_pop),
      .pop_data  (q_data),
      .status    (q_status)
   );

   // Back: clip, square, accumulate and hold the result.
   pcm24_back #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (!q_status.empty),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   `PCM24_ASSERT_NEXT(a_accept_fills_queue, req_valid && req_ready, !q_status.empty, "accepted request missing from queue")
   `PCM24_ASSERT_IMP(a_full_blocks_req, q_status.full, !req_ready && !q_status.empty, "queue full but request side open")
   `PCM24_ASSERT_IMP(a_sat_counted, rsp_valid && rsp_payload.sample_saturated, rsp_payload.saturated_total != '0, "clipped sample not counted")
   `PCM24_ASSERT_IMP(a_nonfinite_flagged, rsp_valid && rsp_payload.sample_nonfinite, rsp_payload.block_error == ERR_NONFINITE, "non-finite sample without block error")

endmodule
